// ----- rtl/core/pcq_pkg.sv -----
// Package: types, constants and the control program of the pad key event queue.
package pcq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int PAD_W           = 21;
    localparam int BTN_W           = 16;
    localparam int BTN_IDX_W       = 4;
    localparam int KEY_W           = 8;
    localparam int ENTRY_W         = KEY_W + 1;
    localparam int PC_W            = 5;

    localparam logic [PC_W-1:0] POP_ENTRY = 5'd21;

    localparam int SHARE_BIT = 0;
    localparam int L3_BIT    = 1;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_EVT,
        OP_POP_RD,
        OP_POP_OUT
    } t_op;

    typedef enum logic {
        COND_NONE,
        COND_POP
    } t_cond;

    typedef enum logic [1:0] {
        MOD_NONE,
        MOD_SHARE,
        MOD_L3
    } t_mod;

    typedef struct packed {
        t_op                  op;
        t_cond                cond;
        logic [PC_W-1:0]      jmp;
        logic                 last;
        t_mod                 mdf;
        logic [BTN_IDX_W-1:0] btn;
        logic [KEY_W-1:0]     key;
    } t_cw;

    typedef struct packed {
        logic active;
        t_cw  cw;
    } t_ctl;

    function automatic t_cw evt(input t_mod m, input logic [BTN_IDX_W-1:0] b,
                                input logic [KEY_W-1:0] k, input logic l);
        return '{OP_EVT, COND_NONE, '0, l, m, b, k};
    endfunction

    function automatic t_cw rom_word(input logic [PC_W-1:0] pc);
        t_cw w;
        w = '{OP_NOP, COND_NONE, '0, 1'b1, MOD_NONE, '0, '0};
        case (pc)
            5'd0:  w = '{OP_NOP, COND_POP, POP_ENTRY, 1'b0, MOD_NONE, '0, '0};
            5'd1:  w = evt(MOD_NONE,  4'd4,  8'had, 1'b0);
            5'd2:  w = evt(MOD_NONE,  4'd6,  8'haf, 1'b0);
            5'd3:  w = evt(MOD_NONE,  4'd7,  8'hac, 1'b0);
            5'd4:  w = evt(MOD_NONE,  4'd5,  8'hae, 1'b0);
            5'd5:  w = evt(MOD_NONE,  4'd14, 8'ha0, 1'b0);
            5'd6:  w = evt(MOD_NONE,  4'd15, 8'h20, 1'b0);
            5'd7:  w = evt(MOD_NONE,  4'd13, 8'h0d, 1'b0);
            5'd8:  w = evt(MOD_NONE,  4'd3,  8'h1b, 1'b0);
            5'd9:  w = evt(MOD_NONE,  4'd12, 8'h09, 1'b0);
            5'd10: w = evt(MOD_NONE,  4'd10, 8'ha2, 1'b0);
            5'd11: w = evt(MOD_NONE,  4'd11, 8'ha4, 1'b0);
            5'd12: w = evt(MOD_NONE,  4'd8,  8'hbb, 1'b0);
            5'd13: w = evt(MOD_NONE,  4'd9,  8'hbc, 1'b0);
            5'd14: w = evt(MOD_SHARE, 4'd14, 8'h31, 1'b0);
            5'd15: w = evt(MOD_SHARE, 4'd15, 8'h32, 1'b0);
            5'd16: w = evt(MOD_SHARE, 4'd13, 8'h33, 1'b0);
            5'd17: w = evt(MOD_SHARE, 4'd12, 8'h34, 1'b0);
            5'd18: w = evt(MOD_L3,    4'd14, 8'h35, 1'b0);
            5'd19: w = evt(MOD_L3,    4'd15, 8'h36, 1'b0);
            5'd20: w = evt(MOD_L3,    4'd13, 8'h37, 1'b1);
            5'd21: w = '{OP_POP_RD,  COND_NONE, '0, 1'b0, MOD_NONE, '0, '0};
            5'd22: w = '{OP_POP_OUT, COND_NONE, '0, 1'b1, MOD_NONE, '0, '0};
            default: w = '{OP_NOP, COND_NONE, '0, 1'b1, MOD_NONE, '0, '0};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/pad_change_key_event_queue_core.sv -----
// Top level: pad change detector with key event ring, driven by a microcoded sequencer.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+---------------------------
//  in      | i_action, i_pad_bits                      | taken when start & !busy
//  out     | o_event_valid, o_key_code, o_key_pressed  | o_strobe, one cycle, no stall
//
//  A sample runs one dispatch step, then one control ROM step per map entry.
//  A pop runs dispatch, RAM read and result steps; the RAM read port sets the extra step.
//  busy is high from the cycle after acceptance until the last step is done.
//  Reset (synchronous, active low) clears pointers, previous sample and sequencer.
//  The result strobe cannot be held off; each pop yields exactly one strobe.
module pad_change_key_event_queue_core #(
    parameter int QUEUE_DEPTH = pcq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_action,
    input  logic [pcq_pkg::PAD_W-1:0]  i_pad_bits,
    output logic                       o_strobe,
    output logic                       o_event_valid,
    output logic [pcq_pkg::KEY_W-1:0]  o_key_code,
    output logic                       o_key_pressed
);
    import pcq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic              go;
    t_ctl              ctl;
    logic [BTN_W-1:0]  r_prev;
    logic [BTN_W-1:0]  r_now;
    logic [BTN_W-1:0]  r_chg;
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [PTR_W-1:0]  wr_next;
    logic [PTR_W-1:0]  rd_next;
    logic              r_nonempty;
    logic              mod_ok;
    logic              hit;
    logic              full;
    logic              ev_we;
    logic              pop_rd;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;

    assign go = start && !busy;

    pcq_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_action (i_action),
        .o_busy   (busy),
        .o_ctl    (ctl)
    );

    always_comb begin
        case (ctl.cw.mdf)
            MOD_NONE:  mod_ok = 1'b1;
            MOD_SHARE: mod_ok = r_now[SHARE_BIT];
            MOD_L3:    mod_ok = r_now[L3_BIT];
            default:   mod_ok = 1'b0;
        endcase
    end

    assign wr_next = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign rd_next = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign full    = (wr_next == r_rd);
    assign hit     = r_chg[ctl.cw.btn] && mod_ok;
    assign ev_we   = ctl.active && (ctl.cw.op == OP_EVT) && hit && !full;
    assign pop_rd  = ctl.active && (ctl.cw.op == OP_POP_RD);
    assign wdata   = {ctl.cw.key, r_now[ctl.cw.btn]};

    // Capture sample and change mask; hold previous sample on a pop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (go && !i_action) begin
            r_prev <= i_pad_bits[BTN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && !i_action) begin
            r_now <= i_pad_bits[BTN_W-1:0];
            r_chg <= i_pad_bits[BTN_W-1:0] ^ r_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr       <= '0;
            r_rd       <= '0;
            r_nonempty <= 1'b0;
        end else begin
            if (ev_we) begin
                r_wr <= wr_next;
            end
            if (pop_rd) begin
                r_nonempty <= (r_rd != r_wr);
                if (r_rd != r_wr) begin
                    r_rd <= rd_next;
                end
            end
        end
    end

    pcq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ev_we),
        .i_waddr (r_wr),
        .i_wdata (wdata),
        .i_raddr (r_rd),
        .o_rdata (rdata)
    );

    assign o_strobe      = ctl.active && (ctl.cw.op == OP_POP_OUT);
    assign o_event_valid = r_nonempty;
    assign o_key_code    = r_nonempty ? rdata[ENTRY_W-1:1] : '0;
    assign o_key_pressed = r_nonempty ? rdata[0] : 1'b0;

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a busy window");

    a_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> busy)
        else $error("accepted item did not raise busy");

    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev_we |=> (r_wr != r_rd))
        else $error("enqueue emptied the ring");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_event_valid) |-> (o_key_code == '0 && !o_key_pressed))
        else $error("empty pop returned nonzero payload");
endmodule

// ----- rtl/core/pcq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/pcq_seq.sv -----
// Microcode sequencer: step counter, control ROM and conditional jump.
module pcq_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic          i_action,
    output logic          o_busy,
    output pcq_pkg::t_ctl o_ctl
);
    import pcq_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            r_busy;
    logic            n_busy;
    logic            r_action;
    t_cw             cw;
    logic            take;

    assign cw   = rom_word(r_pc);
    assign take = (cw.cond == COND_POP) && r_action;

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_go) begin
            n_pc   = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (cw.last) begin
                n_busy = 1'b0;
            end
            n_pc = take ? cw.jmp : r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_action <= i_action;
        end
    end

    assign o_busy       = r_busy;
    assign o_ctl.active = r_busy;
    assign o_ctl.cw     = cw;
endmodule
